// ===== sv/pics_pkg.sv =====
// Package for the Poisson inverse-CDF sampler.
// Holds the fixed-point constants and the shared datapath widths.
// Used by the multiplier, the divider and the top level; depends on nothing.
package pics_pkg;

	localparam int MEAN_W = 20;
	localparam int UNI_W = 24;
	localparam int OUT_W = 8;
	localparam int PROB_W = 32;
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DVD_W = 36;
	localparam int DVS_W = 8;

	localparam logic [MUL_W-1:0] L2E_Q30 = 32'd1549082005;
	localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
	localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [PROB_W-1:0] SAT_P = 32'hFFFF_FFFF;
	localparam logic [DVS_W-1:0] HORNER_TERMS = 8'd6;

endpackage

// ===== sv/poisson_inverse_cdf_sampler.sv =====
// Top level of the Poisson inverse-CDF sampler: sequencer, shared units and ports.
// Depends on pics_pkg, pics_mul and pics_div.
// One transfer carries a Q4.16 mean and a Q0.24 uniform and yields one outcome. The block
// holds s_tready low while it works and takes no new item until the outcome transfer is done.
// All arithmetic runs through one registered 32x32 multiplier and one 36-bit divider that
// produces one quotient bit per cycle. exp(-mean) is formed in the setup states S_T, S_F and
// S_Y and six Horner steps of one multiply and one divide each, and then P(0) is formed; each
// searched outcome value then takes one multiply and one divide. The outcome transfer waits
// on m_tready, and the next input can be taken in the cycle after that transfer.
module poisson_inverse_cdf_sampler #(
	parameter int LIMIT_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // mean_rate [19:0], uniform [43:20], zeros above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // outcome [7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int SUM_W = pics_pkg::PROB_W + $clog2(LIMIT_MAX + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_T, S_F, S_Y, S_HM, S_HD, S_HW, S_P0, S_KM, S_KD, S_KW, S_OUT
	} state_t;

	state_t state_q;
	logic [7:0]                       limit_q;
	logic [pics_pkg::MEAN_W-1:0]      mean_q;
	logic [pics_pkg::PROB_W-1:0]      tgt_q;
	logic [pics_pkg::OUT_W-1:0]       lim_q;
	logic [4:0]                       n_q;
	logic [30:0]                      y31_q;
	logic [pics_pkg::PROB_W-1:0]      r_q;
	logic [pics_pkg::DVS_W-1:0]       i_q;
	logic [pics_pkg::PROB_W-1:0]      p_q;
	logic [SUM_W-1:0]                 s_q;
	logic [pics_pkg::OUT_W-1:0]       k_q;
	logic [pics_pkg::OUT_W-1:0]       outcome_q;

	logic [pics_pkg::MUL_W-1:0]  mul_a;
	logic [pics_pkg::MUL_W-1:0]  mul_b;
	logic [pics_pkg::PROD_W-1:0] prod_q;
	logic                        div_start;
	logic [pics_pkg::DVD_W-1:0]  div_dvd;
	logic [pics_pkg::DVS_W-1:0]  div_dvs;
	logic [pics_pkg::DVD_W-1:0]  quot_q;
	logic                        div_done;

	logic [pics_pkg::OUT_W-1:0]  lim_eff;
	logic [32:0]                 p0_sh;
	logic [pics_pkg::PROB_W-1:0] p0;
	logic [pics_pkg::PROB_W-1:0] pk;
	logic [SUM_W-1:0]            s_new;

	pics_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pics_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quot_q   (quot_q),
		.done_q   (div_done)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = outcome_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		lim_eff = (limit_q == 8'd0) ? 8'd1 : limit_q;
		if (int'(lim_eff) > LIMIT_MAX) begin
			lim_eff = 8'(LIMIT_MAX);
		end
		p0_sh = {r_q, 1'b0} >> n_q;
		p0 = p0_sh[32] ? pics_pkg::SAT_P : p0_sh[31:0];
		pk = (quot_q[pics_pkg::DVD_W-1:32] != '0) ? pics_pkg::SAT_P : quot_q[31:0];
		s_new = s_q + SUM_W'(pk);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_dvd = '0;
		div_dvs = i_q;
		unique case (state_q)
			S_T: begin
				mul_a = pics_pkg::MUL_W'(mean_q);
				mul_b = pics_pkg::L2E_Q30;
			end
			S_F: begin
				mul_a = prod_q[45:14];
				mul_b = pics_pkg::LN2_Q32;
			end
			S_HM: begin
				mul_a = pics_pkg::MUL_W'(y31_q);
				mul_b = r_q;
			end
			S_HD: begin
				div_start = 1'b1;
				div_dvd = pics_pkg::DVD_W'(prod_q[62:31]);
			end
			S_KM: begin
				mul_a = p_q;
				mul_b = pics_pkg::MUL_W'(mean_q);
			end
			S_KD: begin
				div_start = 1'b1;
				div_dvd = prod_q[51:16];
				div_dvs = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 8'd255;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mean_q <= s_tdata[19:0];
						tgt_q <= {s_tdata[43:20], 8'd0};
						lim_q <= lim_eff;
						state_q <= S_T;
					end
				end
				S_T: state_q <= S_F;
				S_F: begin
					n_q <= prod_q[50:46];
					state_q <= S_Y;
				end
				S_Y: begin
					y31_q <= prod_q[63:33];
					r_q <= pics_pkg::ONE_Q31;
					i_q <= pics_pkg::HORNER_TERMS;
					state_q <= S_HM;
				end
				S_HM: state_q <= S_HD;
				S_HD: state_q <= S_HW;
				S_HW: begin
					if (div_done) begin
						r_q <= pics_pkg::ONE_Q31 - quot_q[31:0];
						if (i_q == 8'd1) begin
							state_q <= S_P0;
						end else begin
							i_q <= i_q - 1'b1;
							state_q <= S_HM;
						end
					end
				end
				S_P0: begin
					p_q <= p0;
					s_q <= SUM_W'(p0);
					k_q <= 8'd1;
					if (p0 >= tgt_q) begin
						outcome_q <= '0;
						state_q <= S_OUT;
					end else if (lim_q == 8'd1) begin
						outcome_q <= lim_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_KM;
					end
				end
				S_KM: state_q <= S_KD;
				S_KD: state_q <= S_KW;
				S_KW: begin
					if (div_done) begin
						p_q <= pk;
						s_q <= s_new;
						if (s_new >= SUM_W'(tgt_q)) begin
							outcome_q <= k_q;
							state_q <= S_OUT;
						end else if (k_q + 8'd1 == lim_q) begin
							outcome_q <= lim_q;
							state_q <= S_OUT;
						end else begin
							k_q <= k_q + 8'd1;
							state_q <= S_KM;
						end
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/pics_mul.sv =====
// Shared 32 by 32 bit unsigned multiplier with a registered product.
// Depends on pics_pkg for its widths.
module pics_mul (
	input  logic                          clk,
	input  logic [pics_pkg::MUL_W-1:0]   a,
	input  logic [pics_pkg::MUL_W-1:0]   b,
	output logic [pics_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= pics_pkg::PROD_W'(a) * pics_pkg::PROD_W'(b);
	end

endmodule

// ===== sv/pics_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pics_pkg for its widths; done pulses for one cycle with the quotient.
module pics_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pics_pkg::DVD_W-1:0]  dividend,
	input  logic [pics_pkg::DVS_W-1:0]  divisor,
	output logic [pics_pkg::DVD_W-1:0]  quot_q,
	output logic                         done_q
);

	localparam int CNT_W = $clog2(pics_pkg::DVD_W + 1);

	logic [pics_pkg::DVS_W-1:0] rem_q;
	logic [pics_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [pics_pkg::DVS_W:0]   rem_sh;
	logic [pics_pkg::DVS_W:0]   rem_sub;
	logic                       take;

	always_comb begin
		rem_sh = {rem_q, quot_q[pics_pkg::DVD_W-1]};
		take = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(pics_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[pics_pkg::DVS_W-1:0] : rem_sh[pics_pkg::DVS_W-1:0];
			quot_q <= {quot_q[pics_pkg::DVD_W-2:0], take};
		end
	end

endmodule
